### rtl/core/mlrc_pkg.sv
`default_nettype none
package mlrc_pkg;

    // Text length that is rejected as too long, counted in bytes without a terminating zero.
    localparam int C_MAX_TEXT_BYTES = 32;
    localparam int C_CNT_W = 6;
    localparam logic [C_CNT_W-1:0] C_TEXT_LIMIT = C_CNT_W'(C_MAX_TEXT_BYTES);
    localparam logic [C_CNT_W-1:0] C_WORD16_BYTES = C_CNT_W'(2);
    localparam logic [C_CNT_W-1:0] C_VAL32_BYTES = C_CNT_W'(5);
    localparam logic [C_CNT_W-1:0] C_VAL32_VALUE_BYTES = C_CNT_W'(4);

    localparam logic [15:0] C_CRC_POLY = 16'h1021;
    localparam logic [7:0] C_ADDR_RESET = 8'd128;

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    localparam logic [1:0] FMT_VAL32 = 2'd0;
    localparam logic [1:0] FMT_WORD16 = 2'd1;
    localparam logic [1:0] FMT_TEXT = 2'd2;

    localparam logic [1:0] OC_OK = 2'd0;
    localparam logic [1:0] OC_CRC_BAD = 2'd1;
    localparam logic [1:0] OC_TIMEOUT = 2'd2;
    localparam logic [1:0] OC_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] command_code;
        logic [1:0] reply_format;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] reply_value;
        logic [7:0]  status_byte;
        logic [7:0]  text_byte;
        logic        is_last;
    } t_out_item;

    // CRC-16, MSB first, one byte folded in.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ C_CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    localparam logic [15:0] C_ADDR_CRC_RESET = crc_fold(16'h0000, C_ADDR_RESET);

endpackage
`default_nettype wire

### rtl/core/mlrc_in_reg.sv
`default_nettype none
module mlrc_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire mlrc_pkg::t_in_item i_item,
    input  wire logic              i_go,
    output logic                   o_valid,
    output mlrc_pkg::t_in_item     o_item
);
    import mlrc_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     load;

    assign o_stall = r_valid && !i_go;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

### rtl/core/mlrc_core.sv
`default_nettype none
module mlrc_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_valid,
    input  wire mlrc_pkg::t_in_item i_item,
    input  wire logic               i_slot_free,
    output logic                    o_go,
    output logic                    o_res_valid,
    output mlrc_pkg::t_out_item     o_res
);
    import mlrc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    t_phase             r_phase,   n_phase;
    logic [15:0]        r_crc,     n_crc;
    logic [15:0]        r_addr_crc, n_addr_crc;
    logic [C_CNT_W-1:0] r_count,   n_count;
    logic [31:0]        r_accum,   n_accum;
    logic [7:0]         r_status,  n_status;
    logic [1:0]         r_format,  n_format;
    logic [7:0]         r_crc_hi,  n_crc_hi;

    logic [C_CNT_W-1:0] cnt_inc;
    logic [15:0]        crc_byte;
    logic [7:0]         b;

    assign o_go     = i_valid && i_slot_free;
    assign b        = i_item.rx_byte;
    assign cnt_inc  = r_count + C_CNT_W'(1);
    assign crc_byte = crc_fold(r_crc, b);
    assign n_addr_crc = i_cfg_we ? crc_fold(16'h0000, i_cfg_data) : r_addr_crc;

    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_count     = r_count;
        n_accum     = r_accum;
        n_status    = r_status;
        n_format    = r_format;
        n_crc_hi    = r_crc_hi;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (i_item.req_type)
            REQ_BEGIN: begin
                n_crc    = crc_fold(r_addr_crc, i_item.command_code);
                n_format = (i_item.reply_format == FMT_WORD16 ||
                            i_item.reply_format == FMT_TEXT) ? i_item.reply_format : FMT_VAL32;
                n_phase  = PH_BODY;
                n_count  = '0;
                n_accum  = '0;
                n_status = '0;
                n_crc_hi = '0;
            end
            REQ_TIMEOUT: begin
                if (r_phase != PH_IDLE) begin
                    n_phase           = PH_IDLE;
                    o_res_valid       = 1'b1;
                    o_res.outcome     = OC_TIMEOUT;
                    o_res.is_last     = 1'b1;
                end
            end
            REQ_BYTE: begin
                case (r_phase)
                    PH_BODY: begin
                        n_crc = crc_byte;
                        if (r_format == FMT_TEXT) begin
                            o_res_valid = 1'b1;
                            if (b == 8'h00) begin
                                n_phase = PH_CRC_HI;
                            end else begin
                                n_count         = cnt_inc;
                                o_res.text_byte = b;
                                if (cnt_inc >= C_TEXT_LIMIT) begin
                                    n_phase       = PH_IDLE;
                                    o_res.outcome = OC_TOO_LONG;
                                    o_res.is_last = 1'b1;
                                end
                            end
                        end else if (r_format == FMT_WORD16) begin
                            n_accum = {r_accum[23:0], b};
                            n_count = cnt_inc;
                            if (cnt_inc >= C_WORD16_BYTES) begin
                                n_phase = PH_CRC_HI;
                            end
                        end else begin
                            if (r_count < C_VAL32_VALUE_BYTES) begin
                                n_accum = {r_accum[23:0], b};
                            end else begin
                                n_status = b;
                            end
                            n_count = cnt_inc;
                            if (cnt_inc >= C_VAL32_BYTES) begin
                                n_phase = PH_CRC_HI;
                            end
                        end
                    end
                    PH_CRC_HI: begin
                        n_crc_hi = b;
                        n_phase  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        n_phase           = PH_IDLE;
                        o_res_valid       = 1'b1;
                        o_res.outcome     = ({r_crc_hi, b} == r_crc) ? OC_OK : OC_CRC_BAD;
                        o_res.reply_value = (r_format == FMT_TEXT) ? 32'h0 : r_accum;
                        o_res.status_byte = (r_format == FMT_VAL32) ? r_status : 8'h00;
                        o_res.is_last     = 1'b1;
                    end
                    default: begin
                        // Bytes outside a transaction are dropped.
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_crc      <= '0;
            r_addr_crc <= C_ADDR_CRC_RESET;
            r_count    <= '0;
            r_accum    <= '0;
            r_status   <= '0;
            r_format   <= '0;
            r_crc_hi   <= '0;
        end else begin
            r_addr_crc <= n_addr_crc;
            if (o_go) begin
                r_phase  <= n_phase;
                r_crc    <= n_crc;
                r_count  <= n_count;
                r_accum  <= n_accum;
                r_status <= n_status;
                r_format <= n_format;
                r_crc_hi <= n_crc_hi;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/mlrc_out_reg.sv
`default_nettype none
module mlrc_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire mlrc_pkg::t_out_item i_res,
    output logic                     o_slot_free,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output mlrc_pkg::t_out_item      o_data
);
    import mlrc_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;

    // The slot may be refilled in the same cycle that its transaction completes.
    assign o_slot_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### rtl/core/motor_link_reply_checker_top.sv
// Reply checker for the receive side of a packet-serial motor controller link.
// Input channel (i_in_valid, o_in_stall, i_in_data): one transaction carries a
// begin request with command and reply format, a received byte, or a timeout.
// Output channel (o_out_valid, i_out_stall, o_out_data): at most one result per
// input transaction; text bytes are passed on as they arrive and the final
// result carries outcome, value, status and is_last.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data): the device
// address; o_cfg_ready is always high and writes belong between transactions.
// Each input is held in an input register, processed by combinational logic
// and its result captured in an output register. One input is taken every
// cycle while the output side keeps up; the single byte-wide CRC update sets
// the cycle's logic depth. When the receiver stalls, the result stays in the
// output register; an empty input register still takes one further input
// before o_in_stall rises. Synchronous reset empties both registers, returns
// the checker to idle and sets the device address to 128.
`default_nettype none
module motor_link_reply_checker_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mlrc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mlrc_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_data
);
    import mlrc_pkg::*;

    logic      stg_valid;
    t_in_item  stg_item;
    logic      go;
    logic      slot_free;
    logic      res_valid;
    t_out_item res;

    assign o_cfg_ready = 1'b1;

    mlrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_data),
        .i_go    (go),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    mlrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (stg_valid),
        .i_item      (stg_item),
        .i_slot_free (slot_free),
        .o_go        (go),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mlrc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go && res_valid),
        .i_res       (res),
        .o_slot_free (slot_free),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule
`default_nettype wire

### rtl/core/mlrc_checker.sv
`default_nettype none
module mlrc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire mlrc_pkg::t_out_item o_out_data
);
    import mlrc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or was dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    a_timeout_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.outcome == OC_TIMEOUT) |->
            o_out_data.is_last && (o_out_data.reply_value == 32'h0)
            && (o_out_data.text_byte == 8'h00))
        else $error("timeout result malformed");

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.outcome == OC_TOO_LONG) |->
            o_out_data.is_last && (o_out_data.text_byte != 8'h00))
        else $error("text overflow result malformed");

    a_text_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_last |->
            (o_out_data.outcome == OC_OK) && (o_out_data.reply_value == 32'h0)
            && (o_out_data.status_byte == 8'h00))
        else $error("intermediate text result malformed");

endmodule

bind motor_link_reply_checker_top mlrc_checker u_mlrc_checker (.*);
`default_nettype wire
